// ===== hw/rtl/dictionary_longest_match_coder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dictionary longest-match coder
// Concurrent checks sampled on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DICTIONARY_LONGEST_MATCH_CODER_TOP_ASSERT_SVH
`define DICTIONARY_LONGEST_MATCH_CODER_TOP_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define DLMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define DLMC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

`endif

// ===== hw/rtl/dlmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlmc_pkg
// Shared sizes, codes and beat types of the dictionary longest-match coder.
// ----------------------------------------------------------------------------
package dlmc_pkg;

    localparam int DICT_ENTRIES = 256;
    localparam int MAX_LEN      = 8;
    localparam int RESULT_CAP   = 8;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = 8;
    localparam int POS_W      = 3;
    localparam int ENT_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int DICT_AW = $clog2(DICT_ENTRIES);
    localparam int FILL_W  = $clog2(MAX_LEN + 1);
    localparam int TOK_W   = $clog2(RESULT_CAP + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR    = 2'd2;

    // input beat actions
    localparam logic ACT_DICT = 1'b0;
    localparam logic ACT_TEXT = 1'b1;

    typedef logic [MAX_LEN-1:0][BYTE_W-1:0] t_row;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] byte_value;
        logic              is_last;
        logic [IDX_W-1:0]  entry_index;
        logic [POS_W-1:0]  char_pos;
        logic [LEN_W-1:0]  entry_len;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0] token_index;
        logic [LEN_W-1:0] match_len;
        logic             last_token;
    } t_out_beat;

    typedef enum logic [1:0] {
        WIN_HOLD = 2'd0,
        WIN_PUSH = 2'd1,
        WIN_ADV  = 2'd2,
        WIN_CLR  = 2'd3
    } t_win_op;

    typedef struct packed {
        t_win_op           op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_win_cmd;

    typedef struct packed {
        logic               en;
        logic [DICT_AW-1:0] addr;
        logic [POS_W-1:0]   lane;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   len;
    } t_dict_wr;

endpackage

// ===== hw/rtl/dictionary_longest_match_coder_top.sv =====
// ----------------------------------------------------------------------------
// dictionary_longest_match_coder_top
// Static-dictionary greedy longest-match coder with a shared entry compare
// unit walked over the dictionary by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Beat
//  --------  ---------  ---------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall      t_in_beat (dict byte / text)
//  out       source     o_out_valid / i_out_stall    t_out_beat (one token)
//  cfg       sink       i_cfg_valid / o_cfg_ready    register index + data
//
//  A dictionary beat is written in the cycle it is accepted; the next beat may
//  follow at once.
//  A text beat holds the input until the sequencer is idle again. With N the
//  clamped entry_count, each match attempt streams all N entries through the
//  single dictionary read port and compare unit, one entry per cycle. A flush
//  makes up to 8 attempts; the hold stretches only while the output stalls.
//  Reset clears control state only; the dictionary has no clearing pass.
//  The output register holds a token while i_out_stall is high.
//
module dictionary_longest_match_coder_top
    import dlmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // One-hot sequencer states.
    //   IDLE    take beats
    //   NEXT    decide whether another match attempt follows
    //   SCAN    stream dictionary entries through the compare unit
    //   RESOLVE emit or drop at the window head, advance the window
    //   PUSH    hand the held token to the output register
    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_NEXT    = 5'b00010,
        S_SCAN    = 5'b00100,
        S_RESOLVE = 5'b01000,
        S_PUSH    = 5'b10000
    } t_state;

    t_state              r_state, n_state;

    // configuration registers
    logic [ENT_W-1:0]    r_ent_cnt;
    logic [LEN_W-1:0]    r_max_len;
    logic [BYTE_W-1:0]   r_pad;

    // scan bookkeeping
    logic [ENT_W-1:0]    r_addr, n_addr;
    logic                r_rd_vld, n_rd_vld;
    logic [DICT_AW-1:0]  r_rd_idx, n_rd_idx;
    logic [LEN_W-1:0]    r_best_len, n_best_len;
    logic [DICT_AW-1:0]  r_best_idx, n_best_idx;

    // per-item control
    logic                r_flush, n_flush;
    logic                r_again, n_again;
    logic [TOK_W-1:0]    r_tok_cnt, n_tok_cnt;

    // held token: its last flag is known only once the flush ends
    logic                r_pend_vld, n_pend_vld;
    t_out_beat           r_pend, n_pend;

    // output register
    logic                r_out_vld;
    t_out_beat           r_out;
    logic                out_load;
    t_out_beat           out_data;
    logic                out_free;

    logic                in_acc;
    logic [ENT_W-1:0]    ent_lim;
    logic [LEN_W-1:0]    win_size;
    logic                scan_go;

    t_dict_wr            dict_wr;
    logic                rd_en;
    t_row                rd_row;
    logic [LEN_W-1:0]    rd_len;

    t_win_cmd            win_cmd;
    t_row                win_view;
    logic [FILL_W-1:0]   win_fill;
    logic                hit;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || !i_out_stall;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_cnt <= '0;
            r_max_len <= LEN_W'(8);
            r_pad     <= BYTE_W'(126);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENTRY_COUNT: r_ent_cnt <= i_cfg_data[ENT_W-1:0];
                CFG_MAX_MATCH:   r_max_len <= i_cfg_data[LEN_W-1:0];
                CFG_PAD_CHAR:    r_pad     <= i_cfg_data[BYTE_W-1:0];
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // Clamp the entry count to the store depth and the window size to 1..MAX_LEN.
    assign ent_lim = (r_ent_cnt > ENT_W'(DICT_ENTRIES)) ? ENT_W'(DICT_ENTRIES) : r_ent_cnt;

    always_comb begin
        if (r_max_len == '0) begin
            win_size = LEN_W'(1);
        end else if (int'(r_max_len) > MAX_LEN) begin
            win_size = LEN_W'(MAX_LEN);
        end else begin
            win_size = r_max_len;
        end
    end

    // ------------------------------------------------------------------
    // Dictionary store: written straight from an accepted dictionary beat
    // ------------------------------------------------------------------
    always_comb begin
        dict_wr.en   = in_acc && (i_in.action == ACT_DICT)
                    && (int'(i_in.entry_index) < DICT_ENTRIES)
                    && (int'(i_in.char_pos) < MAX_LEN);
        dict_wr.addr = i_in.entry_index[DICT_AW-1:0];
        dict_wr.lane = i_in.char_pos;
        dict_wr.data = i_in.byte_value;
        dict_wr.len  = i_in.entry_len;
    end

    dlmc_dict u_dict (
        .i_clk     (i_clk),
        .i_wr      (dict_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[DICT_AW-1:0]),
        .o_rd_row  (rd_row),
        .o_rd_len  (rd_len)
    );

    dlmc_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (win_cmd),
        .i_pad   (r_pad),
        .o_view  (win_view),
        .o_fill  (win_fill)
    );

    dlmc_cmp u_cmp (
        .i_row      (rd_row),
        .i_len      (rd_len),
        .i_view     (win_view),
        .i_win_size (win_size),
        .o_hit      (hit)
    );

    // During a flush keep matching while text remains and the token cap is
    // not hit; otherwise make one attempt once the window holds a full frame.
    assign scan_go = r_flush
                   ? ((win_fill != '0) && (r_tok_cnt < TOK_W'(RESULT_CAP)))
                   : (r_again && (int'(win_fill) >= int'(win_size)));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_best_len = r_best_len;
        n_best_idx = r_best_idx;
        n_flush    = r_flush;
        n_again    = r_again;
        n_tok_cnt  = r_tok_cnt;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        out_data   = r_pend;
        win_cmd.op   = WIN_HOLD;
        win_cmd.data = i_in.byte_value;
        win_cmd.len  = r_best_len;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.action == ACT_TEXT)) begin
                    win_cmd.op = WIN_PUSH;
                    n_flush    = i_in.is_last;
                    n_again    = 1'b1;
                    n_tok_cnt  = '0;
                    n_state    = S_NEXT;
                end
            end

            S_NEXT: begin
                if (scan_go) begin
                    n_addr     = '0;
                    n_best_len = '0;
                    n_again    = 1'b0;
                    n_state    = S_SCAN;
                end else begin
                    // flush cap reached: discard the leftover text
                    if (r_flush && (win_fill != '0)) begin
                        win_cmd.op = WIN_CLR;
                    end
                    n_state = r_pend_vld ? S_PUSH : S_IDLE;
                end
            end

            S_SCAN: begin
                // issue one read per cycle, then drain the read register
                if (r_addr < ent_lim) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr[DICT_AW-1:0];
                    n_addr   = r_addr + ENT_W'(1);
                end else if (!r_rd_vld) begin
                    n_state = S_RESOLVE;
                end
                // strictly longer wins, so ties keep the lowest index
                if (r_rd_vld && hit && (rd_len > r_best_len)) begin
                    n_best_len = rd_len;
                    n_best_idx = r_rd_idx;
                end
            end

            S_RESOLVE: begin
                if (r_best_len == '0) begin
                    // no entry matches: drop one byte
                    win_cmd.op  = WIN_ADV;
                    win_cmd.len = LEN_W'(1);
                    n_state     = S_NEXT;
                end else if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        out_load = 1'b1;
                    end
                    n_pend_vld         = 1'b1;
                    n_pend.token_index = IDX_W'(r_best_idx);
                    n_pend.match_len   = r_best_len;
                    n_pend.last_token  = 1'b0;
                    win_cmd.op         = WIN_ADV;
                    n_tok_cnt          = r_tok_cnt + TOK_W'(1);
                    n_state            = S_NEXT;
                end
            end

            S_PUSH: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_data.last_token = r_flush;
                    n_pend_vld          = 1'b0;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_vld   <= 1'b0;
            r_flush    <= 1'b0;
            r_again    <= 1'b0;
            r_tok_cnt  <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_flush    <= n_flush;
            r_again    <= n_again;
            r_tok_cnt  <= n_tok_cnt;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_best_len <= n_best_len;
        r_best_idx <= n_best_idx;
        r_pend     <= n_pend;
    end

    // ------------------------------------------------------------------
    // Output register: hold the token until the sink takes it
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/dlmc_dict.sv =====
// ----------------------------------------------------------------------------
// dlmc_dict
// Dictionary store: one row of entry bytes plus the entry length per index,
// byte-lane writes, one registered row read per cycle.
// ----------------------------------------------------------------------------
module dlmc_dict
    import dlmc_pkg::*;
(
    input  logic               i_clk,
    input  t_dict_wr           i_wr,
    input  logic               i_rd_en,
    input  logic [DICT_AW-1:0] i_rd_addr,
    output t_row               o_rd_row,
    output logic [LEN_W-1:0]   o_rd_len
);

    logic [BYTE_W-1:0] r_bytes [DICT_ENTRIES][MAX_LEN];
    logic [LEN_W-1:0]  r_lens  [DICT_ENTRIES];
    t_row              r_rd_row;
    logic [LEN_W-1:0]  r_rd_len;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_lens[i_wr.addr] <= i_wr.len;
            for (int k = 0; k < MAX_LEN; k++) begin
                if (int'(i_wr.lane) == k) begin
                    r_bytes[i_wr.addr][k] <= i_wr.data;
                end
            end
        end
        if (i_rd_en) begin
            for (int k = 0; k < MAX_LEN; k++) begin
                r_rd_row[k] <= r_bytes[i_rd_addr][k];
            end
            r_rd_len <= r_lens[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;
    assign o_rd_len = r_rd_len;

endmodule

// ===== hw/rtl/dlmc_win.sv =====
// ----------------------------------------------------------------------------
// dlmc_win
// Lookahead window: push text bytes, advance by a match length, flush.
// Positions at or past the fill level read as the pad byte.
// ----------------------------------------------------------------------------
module dlmc_win
    import dlmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_win_cmd          i_cmd,
    input  logic [BYTE_W-1:0] i_pad,
    output t_row              o_view,
    output logic [FILL_W-1:0] o_fill
);

    t_row              r_win, n_win;
    logic [FILL_W-1:0] r_fill, n_fill;

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        unique case (i_cmd.op)
            WIN_PUSH: begin
                if (int'(r_fill) >= MAX_LEN) begin
                    // full: drop the oldest byte, append at the tail
                    for (int k = 0; k < MAX_LEN - 1; k++) begin
                        n_win[k] = r_win[k + 1];
                    end
                    n_win[MAX_LEN-1] = i_cmd.data;
                end else begin
                    for (int k = 0; k < MAX_LEN; k++) begin
                        if (int'(r_fill) == k) begin
                            n_win[k] = i_cmd.data;
                        end
                    end
                    n_fill = r_fill + FILL_W'(1);
                end
            end
            WIN_ADV: begin
                if (int'(i_cmd.len) >= int'(r_fill)) begin
                    n_fill = '0;
                end else begin
                    for (int k = 0; k < MAX_LEN; k++) begin
                        for (int j = 0; j < MAX_LEN; j++) begin
                            if (j == k + int'(i_cmd.len)) begin
                                n_win[k] = r_win[j];
                            end
                        end
                    end
                    n_fill = r_fill - FILL_W'(i_cmd.len);
                end
            end
            WIN_CLR: begin
                n_fill = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_comb begin
        for (int k = 0; k < MAX_LEN; k++) begin
            o_view[k] = (k < int'(r_fill)) ? r_win[k] : i_pad;
        end
    end

    assign o_fill = r_fill;

endmodule

// ===== hw/rtl/dlmc_cmp.sv =====
// ----------------------------------------------------------------------------
// dlmc_cmp
// Entry compare unit: does one dictionary row match the window prefix?
// ----------------------------------------------------------------------------
module dlmc_cmp
    import dlmc_pkg::*;
(
    input  t_row             i_row,
    input  logic [LEN_W-1:0] i_len,
    input  t_row             i_view,
    input  logic [LEN_W-1:0] i_win_size,
    output logic             o_hit
);

    always_comb begin
        // empty entries and entries longer than the window never match
        o_hit = (i_len != '0) && (i_len <= i_win_size);
        for (int k = 0; k < MAX_LEN; k++) begin
            if ((k < int'(i_len)) && (i_row[k] != i_view[k])) begin
                o_hit = 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/dlmc_checker.sv =====
// ----------------------------------------------------------------------------
// dlmc_checker
// Port-level checks of the coder, bound to the top level.
// ----------------------------------------------------------------------------
`include "dictionary_longest_match_coder_top_assert.svh"

module dlmc_checker
    import dlmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out
);

    // a text beat always starts a busy phase
    `DLMC_ASSERT_NEXT(a_text_busy, i_in_valid && !o_in_stall && (i_in.action == ACT_TEXT), o_in_stall)

    // a dictionary beat is absorbed without a busy phase
    `DLMC_ASSERT_NEXT(a_dict_free, i_in_valid && !o_in_stall && (i_in.action == ACT_DICT), !o_in_stall)

    // every token covers between one byte and the longest entry
    `DLMC_ASSERT_NOW(a_len_range, o_out_valid, (o_out.match_len != '0) && (int'(o_out.match_len) <= MAX_LEN))

    // a stalled token is held unchanged
    `DLMC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

endmodule

bind dictionary_longest_match_coder_top dlmc_checker u_dlmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== tb/dlmc_token_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dlmc_token_checker
// Follows every dictionary, register and text beat that the coder accepts,
// works out the tokens that each text beat yields and compares them, field by
// field and in order, with the tokens that leave the output channel.
// ----------------------------------------------------------------------------
module dlmc_token_checker
    import dlmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_beat              i_in,

    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_beat             i_out,

    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    output int                    o_fail_count,
    output int                    o_tokens_owed
);

    logic [BYTE_W-1:0] entry_bytes [DICT_ENTRIES][MAX_LEN];
    logic [LEN_W-1:0]  entry_len   [DICT_ENTRIES];
    logic [BYTE_W-1:0] lookahead   [MAX_LEN];
    int unsigned       held = 0;
    logic [ENT_W-1:0]  reg_entries = '0;
    logic [LEN_W-1:0]  reg_span = LEN_W'(MAX_LEN);
    logic [BYTE_W-1:0] reg_pad = 8'h7E;
    t_out_beat         owed_tokens [$];
    t_out_beat         fresh_tokens [$];
    int                fails = 0;

    initial begin
        o_fail_count  = 0;
        o_tokens_owed = 0;
    end

    function automatic int unsigned span_now();
        if (reg_span == 0) return 1;
        if (reg_span > MAX_LEN) return MAX_LEN;
        return reg_span;
    endfunction

    // past the held text the window reads as the pad byte
    function automatic logic [BYTE_W-1:0] window_byte(input int unsigned pos);
        return (pos < held) ? lookahead[pos] : reg_pad;
    endfunction

    // Longest entry equal to the window prefix; of equal lengths the lowest
    // index wins. Returns 0 when nothing matches.
    function automatic int unsigned longest_match(output logic [IDX_W-1:0] idx);
        int unsigned n;
        int unsigned len;
        int unsigned z;
        int unsigned k;
        bit          same;
        n   = (reg_entries > DICT_ENTRIES) ? DICT_ENTRIES : reg_entries;
        idx = '0;
        for (len = span_now(); len >= 1; len--) begin
            for (z = 0; z < n; z++) begin
                if (entry_len[z] == len) begin
                    same = 1'b1;
                    for (k = 0; k < len; k++) begin
                        if (entry_bytes[z][k] != window_byte(k)) same = 1'b0;
                    end
                    if (same) begin
                        idx = IDX_W'(z);
                        return len;
                    end
                end
            end
        end
        return 0;
    endfunction

    // drop n bytes off the head and refill the tail with the pad byte
    function automatic void slide(input int unsigned n);
        int unsigned i;
        if (n >= held) begin
            held = 0;
        end else begin
            for (i = 0; i + n < held; i++) lookahead[i] = lookahead[i + n];
            held -= n;
        end
        for (i = held; i < MAX_LEN; i++) lookahead[i] = reg_pad;
    endfunction

    function automatic void match_head();
        logic [IDX_W-1:0] idx;
        int unsigned      len;
        len = longest_match(idx);
        if (len == 0) begin
            slide(1);
        end else begin
            fresh_tokens.push_back('{token_index: idx, match_len: LEN_W'(len),
                                     last_token: 1'b0});
            slide(len);
        end
    endfunction

    function automatic void take_beat(input t_in_beat beat);
        fresh_tokens.delete();
        if (beat.action == ACT_DICT) begin
            if (beat.entry_index < DICT_ENTRIES && beat.char_pos < MAX_LEN) begin
                entry_bytes[beat.entry_index][beat.char_pos] = beat.byte_value;
                entry_len[beat.entry_index] = beat.entry_len;
            end
            return;
        end
        if (held >= MAX_LEN) slide(1);
        lookahead[held] = beat.byte_value;
        held++;
        if (!beat.is_last) begin
            if (held >= span_now()) match_head();
        end else begin
            // flush: match until the text is used up, at most one burst of tokens
            while (held > 0 && fresh_tokens.size() < RESULT_CAP) match_head();
            if (held > 0) slide(held);
            if (fresh_tokens.size() > 0) begin
                fresh_tokens[fresh_tokens.size() - 1].last_token = 1'b1;
            end
        end
        foreach (fresh_tokens[i]) owed_tokens.push_back(fresh_tokens[i]);
    endfunction

    function automatic void check_token(input t_out_beat got);
        t_out_beat want;
        if (owed_tokens.size() == 0) begin
            $error("unexpected token: token_index %0d match_len %0d last_token %0b",
                   got.token_index, got.match_len, got.last_token);
            fails++;
            return;
        end
        want = owed_tokens.pop_front();
        if (got.token_index !== want.token_index) begin
            $error("token_index: expected %0d, actual %0d", want.token_index, got.token_index);
            fails++;
        end
        if (got.match_len !== want.match_len) begin
            $error("match_len: expected %0d, actual %0d", want.match_len, got.match_len);
            fails++;
        end
        if (got.last_token !== want.last_token) begin
            $error("last_token: expected %0b, actual %0b", want.last_token, got.last_token);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        int i;
        int j;
        if (!i_rst_n) begin
            for (i = 0; i < DICT_ENTRIES; i++) begin
                entry_len[i] = '0;
                for (j = 0; j < MAX_LEN; j++) entry_bytes[i][j] = '0;
            end
            reg_entries = '0;
            reg_span    = LEN_W'(MAX_LEN);
            reg_pad     = 8'h7E;
            for (j = 0; j < MAX_LEN; j++) lookahead[j] = reg_pad;
            held = 0;
            owed_tokens.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENTRY_COUNT: reg_entries = i_cfg_data[ENT_W-1:0];
                    CFG_MAX_MATCH:   reg_span    = i_cfg_data[LEN_W-1:0];
                    CFG_PAD_CHAR:    reg_pad     = i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) take_beat(i_in);
            if (i_out_valid && !i_out_stall) check_token(i_out);
        end
        o_fail_count  <= fails;
        o_tokens_owed <= owed_tokens.size();
    end

endmodule

// ===== tb/tb_dictionary_longest_match_coder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dictionary_longest_match_coder_top
// Loads dictionaries, steps the coder through a series of register settings
// and feeds text built mostly from dictionary entries, with idle bursts on
// both channels. The token checker beside the block checks every token.
// ----------------------------------------------------------------------------
module tb_dictionary_longest_match_coder_top;
    import dlmc_pkg::*;

    // quiet cycles tolerated; the slowest legal gap is a full flush at 256
    // entries plus the settle pause
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    tokens_owed;

    // stimulus copy of the dictionary, used to compose text that matches
    logic [BYTE_W-1:0] shadow_bytes [DICT_ENTRIES][MAX_LEN];
    int unsigned       shadow_len [DICT_ENTRIES];
    int unsigned       live_entries = 0;       // entry_count after clamping
    logic [BYTE_W-1:0] live_pad = 8'h7E;
    int unsigned       text_sent = 0;
    bit                tx_bursts = 1'b0;
    bit                rx_bursts = 1'b0;
    int unsigned       hold_requests = 0;
    int unsigned       holds_served = 0;
    int unsigned       stall_left = 0;
    int unsigned       quiet_cycles = 0;

    always #5 clk = ~clk;

    dictionary_longest_match_coder_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dlmc_token_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_beat),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_beat),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_tokens_owed (tokens_owed)
    );

    // Receiver: short random stall bursts, or one long hold-off on request.
    // The hold is counted here so the sender keeps offering beats meanwhile.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            if (hold_requests != holds_served) begin
                holds_served++;
                stall_left = LONG_HOLD;
            end else if (rx_bursts && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
        end
        if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles with no beat on any channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL dictionary_longest_match_coder_top");
            $finish;
        end
    end

    // mostly a small alphabet so entries overlap and text matches often
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 3) != 0) begin
            b = 8'h61 + 8'($urandom_range(0, 3));
        end else begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    function automatic t_row random_row();
        t_row row;
        int   i;
        for (i = 0; i < MAX_LEN; i++) row[i] = pick_byte();
        return row;
    endfunction

    // Offer one beat and hold it until taken. Valid stays high on return so
    // a back-to-back beat never lowers and raises it in the same step.
    task automatic send_beat(input t_in_beat beat);
        if (tx_bursts && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Write one entry: every byte below its length, each beat carrying the
    // length. A zero-length entry still takes one beat to set its length.
    task automatic load_entry(input int unsigned idx, input int unsigned len,
                              input t_row row);
        int unsigned writes;
        int unsigned p;
        t_in_beat    beat;
        writes = (len == 0) ? 1 : len;
        shadow_len[idx] = len;
        for (p = 0; p < writes; p++) begin
            shadow_bytes[idx][p] = row[p];
            beat = '{action: ACT_DICT, byte_value: row[p], is_last: 1'($urandom),
                     entry_index: IDX_W'(idx), char_pos: POS_W'(p),
                     entry_len: LEN_W'(len)};
            send_beat(beat);
        end
    endtask

    task automatic send_text(input logic [BYTE_W-1:0] b, input bit last);
        t_in_beat beat;
        beat = '{action: ACT_TEXT, byte_value: b, is_last: last,
                 entry_index: IDX_W'($urandom), char_pos: POS_W'($urandom),
                 entry_len: LEN_W'($urandom_range(0, MAX_LEN))};
        send_beat(beat);
        text_sent++;
    endtask

    // Compose a passage from live entries with some noise and pad bytes mixed
    // in; flush on its last byte if asked, else leave the window loaded.
    task automatic send_passage(input int unsigned nbytes, input bit flush);
        logic [BYTE_W-1:0] stream [$];
        int unsigned       z;
        int unsigned       p;
        int unsigned       k;
        while (stream.size() < nbytes) begin
            if (live_entries != 0 && $urandom_range(0, 4) != 0) begin
                z = $urandom_range(0, live_entries - 1);
                for (p = 0; p < shadow_len[z] && p < MAX_LEN; p++) begin
                    stream.push_back(shadow_bytes[z][p]);
                end
            end else if ($urandom_range(0, 2) == 0) begin
                stream.push_back(live_pad);
            end else begin
                stream.push_back(pick_byte());
            end
        end
        for (k = 0; k < nbytes; k++) send_text(stream[k], flush && (k == nbytes - 1));
    endtask

    // Drop valid, wait for every owed token, then let a silent flush finish.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_owed != 0) @(posedge clk);
        repeat (2 + RESULT_CAP * (live_entries + 3) + 8) @(posedge clk);
    endtask

    // Write all three registers back to back; call only while idle.
    task automatic set_config(input int unsigned entries, input int unsigned span,
                              input int unsigned pad);
        logic [CFG_IDX_W-1:0]  reg_idx [3];
        logic [CFG_DATA_W-1:0] reg_val [3];
        int                    i;
        reg_idx = '{CFG_ENTRY_COUNT, CFG_MAX_MATCH, CFG_PAD_CHAR};
        reg_val = '{CFG_DATA_W'(entries), CFG_DATA_W'(span), CFG_DATA_W'(pad)};
        for (i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx[i];
            cfg_data  <= reg_val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        live_entries = (entries > DICT_ENTRIES) ? DICT_ENTRIES : entries;
        live_pad     = BYTE_W'(pad);
    endtask

    // One setting: go idle, reprogram, then stream passages. Some passages
    // end without a flush, so the next setting meets a loaded window.
    task automatic run_phase(input int unsigned entries, input int unsigned span,
                             input int unsigned pad, input int unsigned beats,
                             input bit long_hold);
        int unsigned target;
        int unsigned nb;
        drain();
        set_config(entries, span, pad);
        if (long_hold) hold_requests <= hold_requests + 1;
        target = text_sent + beats;
        while (text_sent < target) begin
            nb = $urandom_range(1, 14);
            if (nb > target - text_sent) nb = target - text_sent;
            send_passage(nb, $urandom_range(0, 3) != 0);
        end
    endtask

    initial begin : stimulus
        int unsigned e;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed dictionary: a duplicate pair, a zero-length entry, an entry
        // ending in the pad byte, and a full-length entry of all ones.
        load_entry(0, 2, t_row'(16'h6261));        // "ab"
        load_entry(1, 3, t_row'(24'h636261));      // "abc"
        load_entry(2, 2, t_row'(16'h6261));        // "ab" again, entry 0 must win
        load_entry(3, 1, t_row'(8'h78));           // "x"
        load_entry(4, 0, t_row'(8'h71));           // zero length, never matches
        load_entry(5, 2, t_row'(16'h7E7A));        // "z" and the pad byte
        load_entry(6, MAX_LEN, {MAX_LEN{8'hFF}});  // longer than the window here
        load_entry(7, 1, t_row'(8'h00));
        drain();
        set_config(8, 4, 8'h7E);

        // longest match first, then a single byte
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h63, 1'b0);
        send_text(8'h78, 1'b0);
        send_text(8'h79, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        // unmatched head byte is dropped
        send_text(8'h71, 1'b0);
        // flush, with the final token running into the padding
        send_text(8'h7A, 1'b1);
        // flush that yields nothing
        send_text(8'h71, 1'b1);
        send_text(8'h00, 1'b1);
        send_text(8'hFF, 1'b1);

        tx_bursts = 1'b1;
        rx_bursts <= 1'b1;

        drain();
        for (e = 8; e < 20; e++) load_entry(e, $urandom_range(0, MAX_LEN), random_row());
        run_phase(20, MAX_LEN, 8'h00, 30, 1'b0);
        // one-byte window under a long output hold, so the input backs up
        run_phase(20, 1, 8'hFF, 25, 1'b1);
        run_phase(20, 0, $urandom_range(0, 255), 20, 1'b0);
        // empty dictionary and an oversized window register
        run_phase(0, 15, 8'h7E, 15, 1'b0);

        // fill the whole dictionary, mostly with short entries
        drain();
        for (e = 20; e < DICT_ENTRIES; e++) load_entry(e, $urandom_range(0, 3), random_row());
        run_phase(DICT_ENTRIES, MAX_LEN, $urandom_range(0, 255), 25, 1'b0);
        run_phase(511, 9, $urandom_range(0, 255), 20, 1'b0);
        while (text_sent < 240) begin
            run_phase($urandom_range(1, DICT_ENTRIES), $urandom_range(1, MAX_LEN),
                      $urandom_range(0, 255), 25, 1'b0);
        end

        // closing stretch at full rate on both sides
        tx_bursts = 1'b0;
        rx_bursts <= 1'b0;
        run_phase($urandom_range(1, DICT_ENTRIES), $urandom_range(1, MAX_LEN),
                  $urandom_range(0, 255), 20, 1'b0);
        drain();

        if (fail_count == 0 && tokens_owed == 0) begin
            $display("PASS dictionary_longest_match_coder_top");
        end else begin
            $display("FAIL dictionary_longest_match_coder_top");
        end
        $finish;
    end

endmodule
